[hw/rtl/nrft_pkg.sv]
// Package for the RMC sentence to FAT timestamp extractor.
// Holds character codes, field constants, scan phase type and digit helpers.
`timescale 1ns / 1ps

package nrft_pkg;

  localparam int unsigned DigitCount = 6;
  localparam int unsigned DigitPosW  = 3;
  localparam int unsigned CommaCntW  = 4;
  localparam int unsigned OffsetW    = 5;
  localparam int unsigned PAddrW     = 3;
  localparam int unsigned PDataW     = 32;

  localparam logic [7:0] AsciiR     = 8'h52;
  localparam logic [7:0] AsciiDot   = 8'h2E;
  localparam logic [7:0] AsciiComma = 8'h2C;
  localparam logic [7:0] AsciiZero  = 8'h30;

  localparam logic [CommaCntW-1:0] SkipCommas  = 4'd8;
  localparam logic [7:0]           YearBias    = 8'd20;
  localparam logic [7:0]           HoursPerDay = 8'd24;
  localparam logic [OffsetW-1:0]   OffsetReset = 5'd5;
  localparam logic [DigitPosW-1:0] DigitLast   = 3'd6;

  localparam logic [PAddrW-1:0] RegUtcOffset = 3'd0;

  typedef enum logic [4:0] {
    PhSeekR     = 5'b00001,
    PhSeekComma = 5'b00010,
    PhTime      = 5'b00100,
    PhSkip      = 5'b01000,
    PhDate      = 5'b10000
  } phase_e;

  typedef logic [3:0] digits_t [DigitCount];

  function automatic logic [3:0] char_digit(input logic [7:0] b);
    logic [7:0] diff;
    diff = b - AsciiZero;
    return diff[3:0];
  endfunction

  function automatic logic [7:0] pair_value(input logic [3:0] hi, input logic [3:0] lo);
    return ({4'b0, hi} * 8'd10) + {4'b0, lo};
  endfunction

endpackage

[hw/rtl/nrft_in_if.sv]
// Input channel: one sentence byte per transaction with buffer markers.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface nrft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       first_of_buffer;
  logic       last_of_buffer;

  modport source (output valid, output text_byte, output first_of_buffer,
                  output last_of_buffer, input ready);
  modport sink   (input valid, input text_byte, input first_of_buffer,
                  input last_of_buffer, output ready);
endinterface

[hw/rtl/nrft_out_if.sv]
// Output channel: found flag with packed FAT date and time words.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface nrft_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] fat_date;
  logic [15:0] fat_time;

  modport source (output valid, output found, output fat_date, output fat_time,
                  input ready);
  modport sink   (input valid, input found, input fat_date, input fat_time,
                  output ready);
endinterface

[hw/rtl/nmea_rmc_fat_timestamp.sv]
// Top level: scans RMC sentence bytes and emits a FAT16 date/time transaction.
// Depends on nrft_pkg, nrft_in_if and nrft_out_if.
// Result path: an accepted byte enters the input register, then its result goes to the result register.
// Throughput: one byte per cycle while the result register is free; the scan state updates once per byte.
// Stalls: a result held by the sink blocks the input register and then input ready.
// Reset: clears scan state, digits and both pipeline registers; UTC offset returns to 5.
`timescale 1ns / 1ps

module nmea_rmc_fat_timestamp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  nrft_in_if.sink                     in_i,
  nrft_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nrft_pkg::PAddrW-1:0] paddr,
  input  logic [nrft_pkg::PDataW-1:0] pwdata,
  output logic [nrft_pkg::PDataW-1:0] prdata,
  output logic                        pready
);

  logic [nrft_pkg::OffsetW-1:0] offset_q;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_first_q;
  logic       s1_last_q;

  nrft_pkg::phase_e                scan_q, scan_d;
  logic [nrft_pkg::CommaCntW-1:0]  comma_q, comma_d;
  logic [nrft_pkg::DigitPosW-1:0]  pos_q, pos_d;
  nrft_pkg::digits_t               time_q, time_d;
  nrft_pkg::digits_t               date_q, date_d;
  logic                            done_q, done_d;

  logic        out_valid_q;
  logic        out_found_q;
  logic [15:0] out_date_q;
  logic [15:0] out_time_q;

  logic        out_free;
  logic        step;
  logic        emit;
  logic        hit;
  logic [15:0] pack_date;
  logic [15:0] pack_time;

  logic [7:0] hour_raw;
  logic [7:0] hour_adj;
  logic [7:0] day_raw;
  logic [7:0] day_adj;
  logic [7:0] year_raw;
  logic [7:0] month_raw;
  logic [7:0] minute_raw;
  logic [7:0] second_raw;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == nrft_pkg::RegUtcOffset) ?
                  {{(nrft_pkg::PDataW - nrft_pkg::OffsetW){1'b0}}, offset_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= nrft_pkg::OffsetReset;
    end else if (psel && penable && pwrite && paddr == nrft_pkg::RegUtcOffset) begin
      offset_q <= pwdata[nrft_pkg::OffsetW-1:0];
    end
  end

  // Handshake
  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = s1_valid_q && out_free;
  assign in_i.ready = out_free || !s1_valid_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.valid && in_i.ready) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_byte_q  <= '0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_i.valid && in_i.ready) begin
        s1_byte_q  <= in_i.text_byte;
        s1_first_q <= in_i.first_of_buffer;
        s1_last_q  <= in_i.last_of_buffer;
      end
    end
  end

  // Scan
  always_comb begin
    scan_d  = scan_q;
    comma_d = comma_q;
    pos_d   = pos_q;
    time_d  = time_q;
    date_d  = date_q;
    done_d  = done_q;
    hit     = 1'b0;
    emit    = 1'b0;

    if (s1_first_q) begin
      scan_d  = nrft_pkg::PhSeekR;
      comma_d = '0;
      pos_d   = '0;
      time_d  = '{default: '0};
      date_d  = '{default: '0};
      done_d  = 1'b0;
    end

    if (!done_d) begin
      unique case (scan_d)
        nrft_pkg::PhSeekR: begin
          if (s1_byte_q == nrft_pkg::AsciiR) begin
            scan_d = nrft_pkg::PhSeekComma;
          end
        end
        nrft_pkg::PhSeekComma: begin
          if (s1_byte_q == nrft_pkg::AsciiComma) begin
            scan_d  = nrft_pkg::PhTime;
            pos_d   = '0;
            comma_d = '0;
          end
        end
        nrft_pkg::PhTime: begin
          if (s1_byte_q == nrft_pkg::AsciiComma && comma_d < nrft_pkg::SkipCommas) begin
            comma_d = comma_d + 1'b1;
          end
          if (pos_d != '0 && s1_byte_q == nrft_pkg::AsciiDot) begin
            pos_d  = '0;
            scan_d = (comma_d >= nrft_pkg::SkipCommas) ? nrft_pkg::PhDate : nrft_pkg::PhSkip;
          end else if (pos_d < nrft_pkg::DigitLast) begin
            time_d[pos_d] = nrft_pkg::char_digit(s1_byte_q);
            pos_d         = pos_d + 1'b1;
          end
        end
        nrft_pkg::PhSkip: begin
          if (s1_byte_q == nrft_pkg::AsciiComma) begin
            comma_d = comma_d + 1'b1;
            if (comma_d >= nrft_pkg::SkipCommas) begin
              scan_d = nrft_pkg::PhDate;
              pos_d  = '0;
            end
          end
        end
        nrft_pkg::PhDate: begin
          if (pos_d != '0 && s1_byte_q == nrft_pkg::AsciiComma) begin
            hit = 1'b1;
          end else if (pos_d < nrft_pkg::DigitLast) begin
            date_d[pos_d] = nrft_pkg::char_digit(s1_byte_q);
            pos_d         = pos_d + 1'b1;
          end
        end
        default: begin
          scan_d = nrft_pkg::PhSeekR;
        end
      endcase

      if (hit || s1_last_q) begin
        emit   = 1'b1;
        done_d = 1'b1;
      end
    end
  end

  // Pack
  always_comb begin
    hour_raw   = nrft_pkg::pair_value(time_d[0], time_d[1]);
    minute_raw = nrft_pkg::pair_value(time_d[2], time_d[3]);
    second_raw = nrft_pkg::pair_value(time_d[4], time_d[5]);
    day_raw    = nrft_pkg::pair_value(date_d[0], date_d[1]);
    month_raw  = nrft_pkg::pair_value(date_d[2], date_d[3]);
    year_raw   = nrft_pkg::pair_value(date_d[4], date_d[5]) + nrft_pkg::YearBias;
    if (hour_raw >= {3'b0, offset_q}) begin
      hour_adj = hour_raw - {3'b0, offset_q};
      day_adj  = day_raw;
    end else begin
      hour_adj = hour_raw + nrft_pkg::HoursPerDay - {3'b0, offset_q};
      day_adj  = day_raw - 8'd1;
    end
    pack_date = {year_raw[6:0], month_raw[3:0], day_adj[4:0]};
    pack_time = {hour_adj[4:0], minute_raw[5:0], second_raw[5:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= nrft_pkg::PhSeekR;
      comma_q <= '0;
      pos_q   <= '0;
      time_q  <= '{default: '0};
      date_q  <= '{default: '0};
      done_q  <= 1'b0;
    end else if (step) begin
      scan_q  <= scan_d;
      comma_q <= comma_d;
      pos_q   <= pos_d;
      time_q  <= time_d;
      date_q  <= date_d;
      done_q  <= done_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      out_date_q  <= '0;
      out_time_q  <= '0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q && emit;
      out_found_q <= hit;
      out_date_q  <= hit ? pack_date : 16'h0000;
      out_time_q  <= hit ? pack_time : 16'h0000;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.found    = out_found_q;
  assign out_o.fat_date = out_date_q;
  assign out_o.fat_time = out_time_q;

endmodule
